// ===== rtl/core/balu_pkg.sv =====
// Shared types and constants for the bit-vector ALU.
package balu_pkg;

  localparam int WIDTH = 32;
  localparam int OP_W = 5;
  localparam int SHAMT_W = $clog2(WIDTH);
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_NEG  = 5'd2,
    OP_MUL  = 5'd3,
    OP_UDIV = 5'd4,
    OP_UREM = 5'd5,
    OP_SHL  = 5'd6,
    OP_LSHR = 5'd7,
    OP_ASHR = 5'd8,
    OP_AND  = 5'd9,
    OP_OR   = 5'd10,
    OP_XOR  = 5'd11,
    OP_XNOR = 5'd12,
    OP_NOT  = 5'd13,
    OP_EQ   = 5'd14,
    OP_ULT  = 5'd15,
    OP_ULE  = 5'd16,
    OP_SLT  = 5'd17,
    OP_SLE  = 5'd18
  } op_t;

  // Which part of the back end produces the final value.
  typedef enum logic [1:0] {
    UNIT_SIMPLE = 2'd0,
    UNIT_MUL    = 2'd1,
    UNIT_DIV    = 2'd2,
    UNIT_REM    = 2'd3
  } unit_t;

  typedef struct packed {
    op_t              op;
    unit_t            unit;
    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/core/balu_front.sv =====
// Front end: takes an incoming word and classifies it by execution unit.
module balu_front (
  input  logic [4:0]             req_type,
  input  logic [31:0]            operand_a,
  input  logic [31:0]            operand_b,
  output balu_pkg::item_t        item
);
  import balu_pkg::*;

  op_t   op;
  unit_t unit;

  always_comb begin
    op = op_t'(req_type);
    unique case (op)
      OP_MUL:  unit = UNIT_MUL;
      OP_UDIV: unit = UNIT_DIV;
      OP_UREM: unit = UNIT_REM;
      default: unit = UNIT_SIMPLE;
    endcase
  end

  assign item.op   = op;
  assign item.unit = unit;
  assign item.a    = operand_a[WIDTH-1:0];
  assign item.b    = operand_b[WIDTH-1:0];

endmodule

// ===== rtl/core/balu_queue.sv =====
// Small register queue between the front end and the back end.
module balu_queue #(
  parameter int DEPTH = balu_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  balu_pkg::item_t            push_item,
  input  logic                       pop,
  output balu_pkg::item_t            head_item,
  output balu_pkg::q_stat_t          stat,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  import balu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  item_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_item  = mem[rd_ptr];
  assign level      = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== rtl/core/balu_back.sv =====
// Back end: execute stage followed by a one-bit-per-stage restoring divider.
module balu_back (
  input  logic              clk,
  input  logic              rst,
  input  balu_pkg::item_t   q_item,
  input  balu_pkg::q_stat_t q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       result,
  output logic              compare_true
);
  import balu_pkg::*;

  logic             en;
  logic             vld [0:WIDTH];
  logic [WIDTH-1:0] rem_s [0:WIDTH];
  logic [WIDTH-1:0] quo_s [0:WIDTH];
  logic [WIDTH-1:0] dvs_s [0:WIDTH];
  logic [WIDTH-1:0] res_s [0:WIDTH];
  logic             flag_s [0:WIDTH];
  logic             bz_s [0:WIDTH];
  unit_t            unit_s [0:WIDTH];

  logic [WIDTH-1:0] res0;
  logic             flag0;
  logic             big_sh;
  logic [SHAMT_W-1:0] shamt;
  logic [WIDTH-1:0] sa;
  logic [WIDTH-1:0] sb;
  logic [WIDTH-1:0] fin_res;

  // The whole pipeline holds while a finished word waits at the output.
  assign en  = !(out_valid && out_stall);
  assign pop = en && !q_stat.empty;

  assign shamt  = q_item.b[SHAMT_W-1:0];
  assign big_sh = (q_item.b >= WIDTH'(WIDTH));
  assign sa     = q_item.a ^ {1'b1, {(WIDTH-1){1'b0}}};
  assign sb     = q_item.b ^ {1'b1, {(WIDTH-1){1'b0}}};

  always_comb begin
    res0  = '0;
    flag0 = 1'b0;
    case (q_item.op)
      OP_ADD:  res0 = q_item.a + q_item.b;
      OP_SUB:  res0 = q_item.a - q_item.b;
      OP_NEG:  res0 = '0 - q_item.a;
      OP_MUL:  res0 = q_item.a * q_item.b;
      OP_SHL:  res0 = big_sh ? '0 : (q_item.a << shamt);
      OP_LSHR: res0 = big_sh ? '0 : (q_item.a >> shamt);
      OP_ASHR: res0 = big_sh ? {WIDTH{q_item.a[WIDTH-1]}}
                             : WIDTH'($signed(q_item.a) >>> shamt);
      OP_AND:  res0 = q_item.a & q_item.b;
      OP_OR:   res0 = q_item.a | q_item.b;
      OP_XOR:  res0 = q_item.a ^ q_item.b;
      OP_XNOR: res0 = ~(q_item.a ^ q_item.b);
      OP_NOT:  res0 = ~q_item.a;
      OP_EQ:   flag0 = (q_item.a == q_item.b);
      OP_ULT:  flag0 = (q_item.a < q_item.b);
      OP_ULE:  flag0 = (q_item.a <= q_item.b);
      OP_SLT:  flag0 = (sa < sb);
      OP_SLE:  flag0 = (sa <= sb);
      default: res0 = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0]  <= '0;
      quo_s[0]  <= q_item.a;
      dvs_s[0]  <= q_item.b;
      res_s[0]  <= res0;
      flag_s[0] <= flag0;
      bz_s[0]   <= (q_item.b == '0);
      unit_s[0] <= q_item.unit;
    end
  end

  for (genvar k = 1; k <= WIDTH; k++) begin : g_div
    logic [WIDTH:0] shifted;
    logic [WIDTH:0] diff;

    assign shifted = {rem_s[k-1], quo_s[k-1][WIDTH-1]};
    assign diff    = shifted - {1'b0, dvs_s[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[WIDTH]) begin
          rem_s[k] <= diff[WIDTH-1:0];
          quo_s[k] <= {quo_s[k-1][WIDTH-2:0], 1'b1};
        end else begin
          rem_s[k] <= shifted[WIDTH-1:0];
          quo_s[k] <= {quo_s[k-1][WIDTH-2:0], 1'b0};
        end
        dvs_s[k]  <= dvs_s[k-1];
        res_s[k]  <= res_s[k-1];
        flag_s[k] <= flag_s[k-1];
        bz_s[k]   <= bz_s[k-1];
        unit_s[k] <= unit_s[k-1];
      end
    end
  end

  always_comb begin
    case (unit_s[WIDTH])
      UNIT_DIV: fin_res = bz_s[WIDTH] ? '0 : quo_s[WIDTH];
      UNIT_REM: fin_res = bz_s[WIDTH] ? '0 : rem_s[WIDTH];
      default:  fin_res = res_s[WIDTH];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result       <= 32'(fin_res);
      compare_true <= flag_s[WIDTH];
    end
  end

endmodule

// ===== rtl/core/bitvector_alu_top.sv =====
// An accepted input word is written into the queue, then passes the execute stage,
// the 32 divider stages and the output register. Throughput: one word per cycle while
// the output is not stalled; execute, divider and output registers advance together.
// An output stall freezes the back end; input is taken until the 4-entry queue fills.
// Reset (synchronous, active high) empties the queue and clears all valid bits.
module bitvector_alu_top #(
  parameter int QDEPTH = balu_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  req_type,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result,
  output logic        compare_true
);
  import balu_pkg::*;

  item_t                      f_item;
  item_t                      q_item;
  q_stat_t                    q_stat;
  logic                       pop;
  logic [$clog2(QDEPTH+1)-1:0] q_level;

  assign in_stall = q_stat.full;

  balu_front u_front (
    .req_type  (req_type),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .item      (f_item)
  );

  balu_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_item (f_item),
    .pop       (pop),
    .head_item (q_item),
    .stat      (q_stat),
    .level     (q_level)
  );

  balu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_item       (q_item),
    .q_stat       (q_stat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result       (result),
    .compare_true (compare_true)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= ($clog2(QDEPTH+1))'(QDEPTH))
    else $error("queue level above depth");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && compare_true) |-> (result == '0))
    else $error("comparison word with nonzero result");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("reset did not empty the block");

endmodule
